// ===== rtl/ogic_pkg.sv =====
// Shared types and constants for the online grid island counter.
// No dependencies; every other file but ogic_ram imports this package.
`default_nettype none

package ogic_pkg;

    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int DIM_W     = 7;
    localparam int CNT_W     = 13;
    localparam int RANK_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [DIM_W-1:0]  DIM_RESET = 7'd64;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 13'd8191;
    localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_SET,
        OP_NB_READ,
        OP_NB_SKIP,
        OP_FIND_START,
        OP_FIND_STEP,
        OP_COMP_STEP,
        OP_ADD,
        OP_JOIN_READ,
        OP_JOIN_APPLY,
        OP_COUNT,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic in_range;
        logic occ_hit;
        logic nb_ok;
        logic k_last;
        logic found;
        logic root_is_nb;
        logic comp_done;
        logic no_roots;
        logic ji_last;
        logic clr_done;
        logic out_full;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/ogic_ifs.sv =====
// Handshake channels of the island counter: request, result, configuration.
// Depends on ogic_pkg for field widths.
`default_nettype none

interface ogic_req_if import ogic_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    modport source (output valid, cell_row, cell_col, input ready);
    modport sink   (input valid, cell_row, cell_col, output ready);
endinterface

interface ogic_rsp_if import ogic_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] island_count;
    logic             range_error;
    modport source (output valid, island_count, range_error, input ready);
    modport sink   (input valid, island_count, range_error, output ready);
endinterface

interface ogic_cfg_if import ogic_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ogic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ogic_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== rtl/ogic_datapath.sv =====
// Datapath: configuration, occupancy/parent/rank tables, root walk, join, count.
// Depends on ogic_pkg and ogic_ram; driven by ogic_ctrl through t_op / t_stat.
`default_nettype none

module ogic_datapath import ogic_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_op                  i_op,
    output t_stat                     o_stat,
    input  wire logic [ROW_W-1:0]     i_req_row,
    input  wire logic [COL_W-1:0]     i_req_col,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic      [CNT_W-1:0]     o_island_count,
    output logic                      o_range_error
);
    localparam int NCELLS = MAX_ROWS * MAX_COLS;
    localparam int CW     = $clog2(NCELLS);
    localparam int PW     = CW + ROW_W + COL_W;

    logic [DIM_W-1:0]  r_grid_rows, r_grid_cols;
    logic [CW-1:0]     r_clr;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [CW-1:0]     r_cell, r_nb, r_node, r_root, r_cur_root;
    logic              r_in_range;
    logic [1:0]        r_k, r_ji;
    logic [CW-1:0]     r_roots [4];
    logic [2:0]        r_nroots;
    logic [RANK_W-1:0] r_cur_rank;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid, r_out_err;
    logic [CNT_W-1:0]  r_out_count;

    logic [DIM_W-1:0]  w_rows, w_cols;
    logic [CW-1:0]     w_req_cell, w_nb, w_join_r;
    logic              w_req_in, w_nb_ok, w_found, w_seen;
    logic              w_occ_q;
    logic [CW-1:0]     w_par_q;
    logic [RANK_W-1:0] w_rank_q, w_rank_inc;
    logic              w_occ_we, w_occ_wd, w_par_we, w_rank_we;
    logic [CW-1:0]     w_occ_wa, w_occ_ra, w_par_wa, w_par_wd, w_par_ra, w_rank_wa;
    logic [RANK_W-1:0] w_rank_wd;
    logic [CNT_W-1:0]  w_drop;

    // clamp dimensions to the table size
    assign w_rows = (int'(r_grid_rows) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : r_grid_rows;
    assign w_cols = (int'(r_grid_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : r_grid_cols;

    assign w_req_in   = ({1'b0, i_req_row} < w_rows) && ({1'b0, i_req_col} < w_cols);
    assign w_req_cell = CW'(PW'(i_req_row) * PW'(MAX_COLS) + PW'(i_req_col));

    // neighbor order: down, up, left, right
    always_comb begin
        w_nb_ok = 1'b0;
        w_nb    = r_cell;
        case (r_k)
            2'd0: begin
                w_nb_ok = ({1'b0, r_row} + 7'd1) < w_rows;
                w_nb    = r_cell + CW'(MAX_COLS);
            end
            2'd1: begin
                w_nb_ok = r_row != '0;
                w_nb    = r_cell - CW'(MAX_COLS);
            end
            2'd2: begin
                w_nb_ok = r_col != '0;
                w_nb    = r_cell - CW'(1);
            end
            default: begin
                w_nb_ok = ({1'b0, r_col} + 7'd1) < w_cols;
                w_nb    = r_cell + CW'(1);
            end
        endcase
    end

    assign w_found    = (w_par_q == r_node);
    assign w_join_r   = r_roots[r_ji];
    assign w_rank_inc = (w_rank_q == RANK_MAX) ? RANK_MAX : w_rank_q + RANK_W'(1);
    assign w_drop     = CNT_W'(r_nroots) - CNT_W'(1);

    always_comb begin
        w_seen = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if ((3'(j) < r_nroots) && (r_roots[j] == r_root)) begin
                w_seen = 1'b1;
            end
        end
    end

    // table port steering
    always_comb begin
        w_occ_we  = 1'b0;
        w_occ_wa  = r_cell;
        w_occ_wd  = 1'b0;
        w_occ_ra  = w_req_cell;
        w_par_we  = 1'b0;
        w_par_wa  = r_cell;
        w_par_wd  = r_cell;
        w_par_ra  = r_nb;
        w_rank_we = 1'b0;
        w_rank_wa = r_cell;
        w_rank_wd = '0;
        case (i_op)
            OP_CLEAR: begin
                w_occ_we = 1'b1;
                w_occ_wa = r_clr;
            end
            OP_SET: begin
                w_occ_we  = 1'b1;
                w_occ_wd  = 1'b1;
                w_par_we  = 1'b1;
                w_rank_we = 1'b1;
            end
            OP_NB_READ:  w_occ_ra = w_nb;
            OP_FIND_STEP: w_par_ra = w_found ? r_nb : w_par_q;
            OP_COMP_STEP: begin
                w_par_we = 1'b1;
                w_par_wa = r_node;
                w_par_wd = r_root;
                w_par_ra = w_par_q;
            end
            OP_JOIN_APPLY: begin
                w_par_we = 1'b1;
                if (w_rank_q < r_cur_rank) begin
                    w_par_wa = w_join_r;
                    w_par_wd = r_cur_root;
                end else begin
                    w_par_wa = r_cur_root;
                    w_par_wd = w_join_r;
                    if (w_rank_q == r_cur_rank) begin
                        w_rank_we = 1'b1;
                        w_rank_wa = w_join_r;
                        w_rank_wd = w_rank_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    ogic_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_occ (
        .i_clk(i_clk), .i_we(w_occ_we), .i_waddr(w_occ_wa), .i_wdata(w_occ_wd),
        .i_raddr(w_occ_ra), .o_rdata(w_occ_q)
    );

    ogic_ram #(.WIDTH(CW), .DEPTH(NCELLS)) u_parent (
        .i_clk(i_clk), .i_we(w_par_we), .i_waddr(w_par_wa), .i_wdata(w_par_wd),
        .i_raddr(w_par_ra), .o_rdata(w_par_q)
    );

    ogic_ram #(.WIDTH(RANK_W), .DEPTH(NCELLS)) u_rank (
        .i_clk(i_clk), .i_we(w_rank_we), .i_waddr(w_rank_wa), .i_wdata(w_rank_wd),
        .i_raddr(w_join_r), .o_rdata(w_rank_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= DIM_RESET;
            r_grid_cols <= DIM_RESET;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_ji        <= '0;
            r_nroots    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                    REG_GRID_COLS: r_grid_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_CLEAR: r_clr <= r_clr + CW'(1);
                OP_SET: begin
                    r_k      <= '0;
                    r_ji     <= '0;
                    r_nroots <= '0;
                end
                OP_NB_SKIP: r_k <= r_k + 2'd1;
                OP_ADD: begin
                    r_k <= r_k + 2'd1;
                    if (!w_seen) begin
                        r_nroots <= r_nroots + 3'd1;
                    end
                end
                OP_JOIN_APPLY: r_ji <= r_ji + 2'd1;
                OP_COUNT: begin
                    if (r_nroots == '0) begin
                        if (r_count < CNT_MAX) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end else if (r_count >= w_drop) begin
                        r_count <= r_count - w_drop;
                    end else begin
                        r_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_row      <= i_req_row;
                r_col      <= i_req_col;
                r_cell     <= w_req_cell;
                r_in_range <= w_req_in;
            end
            OP_SET: begin
                r_cur_root <= r_cell;
                r_cur_rank <= '0;
            end
            OP_NB_READ: r_nb <= w_nb;
            OP_FIND_START: r_node <= r_nb;
            OP_FIND_STEP: begin
                if (w_found) begin
                    r_root <= r_node;
                    r_node <= r_nb;
                end else begin
                    r_node <= w_par_q;
                end
            end
            OP_COMP_STEP: r_node <= w_par_q;
            OP_ADD: begin
                if (!w_seen) begin
                    r_roots[r_nroots[1:0]] <= r_root;
                end
            end
            OP_JOIN_APPLY: begin
                if (w_rank_q >= r_cur_rank) begin
                    r_cur_root <= w_join_r;
                    r_cur_rank <= (w_rank_q == r_cur_rank) ? w_rank_inc : w_rank_q;
                end
            end
            OP_OUT: begin
                r_out_count <= r_count;
                r_out_err   <= !r_in_range;
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_island_count = r_out_count;
    assign o_range_error  = r_out_err;

    assign o_stat.in_range   = r_in_range;
    assign o_stat.occ_hit    = w_occ_q;
    assign o_stat.nb_ok      = w_nb_ok;
    assign o_stat.k_last     = (r_k == 2'd3);
    assign o_stat.found      = w_found;
    assign o_stat.root_is_nb = w_found && (r_node == r_nb);
    assign o_stat.comp_done  = (w_par_q == r_root);
    assign o_stat.no_roots   = (r_nroots == '0);
    assign o_stat.ji_last    = ({1'b0, r_ji} == (r_nroots - 3'd1));
    assign o_stat.clr_done   = (r_clr == CW'(NCELLS - 1));
    assign o_stat.out_full   = r_out_valid;
endmodule

`default_nettype wire

// ===== rtl/ogic_ctrl.sv =====
// Controller state machine: sequences table sweeps, root walks and joins.
// Depends on ogic_pkg; drives ogic_datapath through t_op / t_stat.
`default_nettype none

module ogic_ctrl import ogic_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_op        o_op
);
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_NB_ISSUE = 4'd3;
    localparam logic [3:0] S_NB_WAIT  = 4'd4;
    localparam logic [3:0] S_FIND     = 4'd5;
    localparam logic [3:0] S_COMP     = 4'd6;
    localparam logic [3:0] S_ADD      = 4'd7;
    localparam logic [3:0] S_JOIN_RD  = 4'd8;
    localparam logic [3:0] S_JOIN_AP  = 4'd9;
    localparam logic [3:0] S_COUNT    = 4'd10;
    localparam logic [3:0] S_RESULT   = 4'd11;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.in_range || i_stat.occ_hit) begin
                    n_state = S_RESULT;
                end else begin
                    o_op    = OP_SET;
                    n_state = S_NB_ISSUE;
                end
            end
            S_NB_ISSUE: begin
                if (i_stat.nb_ok) begin
                    o_op    = OP_NB_READ;
                    n_state = S_NB_WAIT;
                end else begin
                    o_op = OP_NB_SKIP;
                    if (i_stat.k_last) n_state = S_JOIN_RD;
                end
            end
            S_NB_WAIT: begin
                if (i_stat.occ_hit) begin
                    o_op    = OP_FIND_START;
                    n_state = S_FIND;
                end else begin
                    o_op    = OP_NB_SKIP;
                    n_state = i_stat.k_last ? S_JOIN_RD : S_NB_ISSUE;
                end
            end
            S_FIND: begin
                o_op = OP_FIND_STEP;
                if (i_stat.found) n_state = i_stat.root_is_nb ? S_ADD : S_COMP;
            end
            S_COMP: begin
                o_op = OP_COMP_STEP;
                if (i_stat.comp_done) n_state = S_ADD;
            end
            S_ADD: begin
                o_op    = OP_ADD;
                n_state = i_stat.k_last ? S_JOIN_RD : S_NB_ISSUE;
            end
            S_JOIN_RD: begin
                if (i_stat.no_roots) begin
                    n_state = S_COUNT;
                end else begin
                    o_op    = OP_JOIN_READ;
                    n_state = S_JOIN_AP;
                end
            end
            S_JOIN_AP: begin
                o_op    = OP_JOIN_APPLY;
                n_state = i_stat.ji_last ? S_COUNT : S_JOIN_RD;
            end
            S_COUNT: begin
                o_op    = OP_COUNT;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!i_stat.out_full || i_out_ready) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted request did not enter check");

    a_find_to_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND && i_stat.found && !i_stat.root_is_nb) |=> (r_state == S_COMP))
        else $error("long chain did not go to compression");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && i_stat.out_full && !i_out_ready) |=> (r_state == S_RESULT))
        else $error("result overwrote a pending response");
endmodule

`default_nettype wire

// ===== rtl/online_grid_island_counter.sv =====
// Online grid island counter: union-find over occupancy, parent and rank tables.
// A request out of range or on a cell already on goes straight to the result; a new cell
// scans each neighbor, skipping those off grid or empty, finds each root with compression
// and joins the distinct roots by rank; one read port per table, one request at a time.
// Sync active-low reset clears the count and sweeps the occupancy table.
// Depends on ogic_pkg, ogic_ifs, ogic_ram, ogic_datapath, ogic_ctrl.
`default_nettype none

module online_grid_island_counter import ogic_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ogic_req_if.sink   i_req,
    ogic_rsp_if.source o_rsp,
    ogic_cfg_if.sink   i_cfg
);
    t_op   w_op;
    t_stat w_stat;

    // configuration writes land directly in the datapath registers
    assign i_cfg.ready = 1'b1;

    // controller: walks each request through check, neighbor scan,
    // root finds with compression, rank joins and the count update
    ogic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_op        (w_op)
    );

    // datapath: tables, neighbor address math, root list, island count
    // and the response register that decouples the output side
    ogic_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .o_stat         (w_stat),
        .i_req_row      (i_req.cell_row),
        .i_req_col      (i_req.cell_col),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_island_count (o_rsp.island_count),
        .o_range_error  (o_rsp.range_error)
    );
endmodule

`default_nettype wire
